// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port checker file of the length decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/core/vld_pkg.sv =====
// Shared types, constants and helper functions of the length decoder.
// No dependencies; used by every module of the block.
package vld_pkg;

   // Largest count of value bytes a long-form header may announce.
   localparam int MAX_VALUE_BYTES = 4;

   // Width of the byte counters; must hold MAX_VALUE_BYTES itself.
   localparam int CntW = $clog2(MAX_VALUE_BYTES + 1);
   // Width of the minimal byte count of a 32-bit value (0 to 4).
   localparam int NeedW = 3;
   localparam int CmpW = (CntW > NeedW) ? CntW : NeedW;

   localparam logic [6:0] MaxCount = 7'(MAX_VALUE_BYTES);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       source_end;
   } req_type;

   typedef struct packed {
      logic [31:0] decoded_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic            collecting;
      logic [CntW-1:0] expected_count;
      logic [CntW-1:0] bytes_left;
      logic [31:0]     accumulator;
   } state_type;

   localparam state_type IdleState = '{
      collecting:     1'b0,
      expected_count: '0,
      bytes_left:     '0,
      accumulator:    '0
   };

   // Number of value bytes a minimal encoding of v uses.
   function automatic logic [NeedW-1:0] bytes_needed(input logic [31:0] v);
      logic [NeedW-1:0] n;
      if (v <= 32'd127) begin
         n = 3'd0;
      end else if (v <= 32'd255) begin
         n = 3'd1;
      end else if (v <= 32'd65535) begin
         n = 3'd2;
      end else if (v <= 32'd16777215) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/vld_decode.sv =====
// Decode state and the per-item decode step of the length decoder.
// Depends on vld_pkg.
module vld_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  vld_pkg::req_type item,
   output logic             result_valid,
   output vld_pkg::rsp_type result
);

   vld_pkg::state_type state_ff;
   vld_pkg::state_type state_in;

   logic [6:0]               count;
   logic [31:0]              acc_shift;
   logic [vld_pkg::CntW-1:0] left_dec;
   logic                     minimal;

   assign count     = item.data_byte[6:0];
   assign acc_shift = {state_ff.accumulator[23:0], item.data_byte};
   assign left_dec  = (state_ff.bytes_left != '0) ? state_ff.bytes_left - 1'b1
                                                  : state_ff.bytes_left;
   assign minimal   = vld_pkg::CmpW'(vld_pkg::bytes_needed(acc_shift)) ==
                      vld_pkg::CmpW'(state_ff.expected_count);

   always_comb begin
      state_in     = state_ff;
      result_valid = 1'b0;
      result       = '{decoded_value: '0, status: vld_pkg::ST_OK};
      if (item.source_end) begin
         state_in      = vld_pkg::IdleState;
         result_valid  = 1'b1;
         result.status = vld_pkg::ST_SHORT;
      end else if (!state_ff.collecting) begin
         if (!item.data_byte[7]) begin
            result_valid         = 1'b1;
            result.decoded_value = {24'd0, item.data_byte};
         end else if (count == 7'd0 || count > vld_pkg::MaxCount) begin
            result_valid  = 1'b1;
            result.status = vld_pkg::ST_BAD;
         end else begin
            state_in.collecting     = 1'b1;
            state_in.expected_count = count[vld_pkg::CntW-1:0];
            state_in.bytes_left     = count[vld_pkg::CntW-1:0];
            state_in.accumulator    = '0;
         end
      end else if (left_dec != '0) begin
         state_in.accumulator = acc_shift;
         state_in.bytes_left  = left_dec;
      end else begin
         // Last value byte: the field is complete, check minimality.
         state_in     = vld_pkg::IdleState;
         result_valid = 1'b1;
         if (minimal) begin
            result.decoded_value = acc_shift;
         end else begin
            result.status = vld_pkg::ST_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vld_pkg::IdleState;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/vlength_decoder.sv =====
// Top level of the DER-style definite length decoder.
// Depends on vld_pkg and vld_decode.
//
// The block takes one source byte, or an end-of-source marker, per item and
// decodes a definite length field: a byte below 0x80 is the length itself,
// otherwise its low seven bits announce 1 to MAX_VALUE_BYTES big-endian value
// bytes. Each completed or failed field yields one result item with the value
// and a status (ok, insufficient bytes, bad or non-minimal length); value
// bytes in the middle of a field yield nothing. One item is taken every
// cycle unless the input side stalls; a result reaches the rsp_ side after
// its item was accepted: the input register holds the item, one decode pass
// computes the result and the result register captures it. The decode state
// is updated in that single pass, so consecutive bytes of one field follow
// each other without a gap. While a result waits under rsp_stall, items that
// produce no result still flow, and the input side stalls only when a new
// result would have nowhere to go.
module vlength_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vld_pkg::rsp_type rsp_data
);

   // Input register.
   logic             in_vld_ff;
   logic             in_vld_in;
   vld_pkg::req_type in_data_ff;

   // Result register.
   logic             out_vld_ff;
   logic             out_vld_in;
   vld_pkg::rsp_type out_data_ff;

   logic             res_vld;
   vld_pkg::rsp_type res_data;
   logic             out_free;
   logic             proc;

   vld_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step_en      (proc),
      .item         (in_data_ff),
      .result_valid (res_vld),
      .result       (res_data)
   );

   // The result register can take a new result when empty or being drained.
   assign out_free  = !out_vld_ff || !rsp_stall;
   // The held item is decoded once its result, if any, has a place to go.
   assign proc      = in_vld_ff && (!res_vld || out_free);
   assign req_stall = in_vld_ff && !proc;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (!in_vld_ff || proc) begin
         in_vld_in = req_valid;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (proc && res_vld) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (proc && res_vld) begin
         out_data_ff <= res_data;
      end
   end

endmodule

// ===== rtl/core/vld_checker.sv =====
// Port-level checks of the length decoder and the bind that attaches them.
// Depends on vld_pkg, assert_macros.svh and vlength_decoder.
`include "assert_macros.svh"

module vld_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input vld_pkg::rsp_type rsp_data
);

   logic failed;

   assign failed = rsp_data.status != vld_pkg::ST_OK;

   // A stalled result stays in place.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // Only the three defined status codes ever leave the block.
   `ASSERT_CLK(a_status_code, clock, reset, rsp_valid |-> rsp_data.status <= vld_pkg::ST_BAD)

   // A failed field always reports a zero value.
   `ASSERT_CLK(a_fail_zero, clock, reset, rsp_valid && failed |-> rsp_data.decoded_value == '0)

   // The input side only stalls while a result is held up on the output side.
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // Reset empties the result register.
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind vlength_decoder vld_port_checks u_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/vld_checker.sv =====
// Checker for the length decoder: watches both channels, predicts the results.
// Depends on vld_pkg for the item types and status codes.
`timescale 1ns / 1ps

module vld_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  vld_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  vld_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   // Decoder state as the bench sees it.
   logic        in_field;
   logic [3:0]  announced_len;
   logic [3:0]  len_remaining;
   logic [31:0] value_acc;

   vld_pkg::rsp_type pending_lengths[$];
   vld_pkg::rsp_type oldest;
   vld_pkg::rsp_type predicted;
   logic             produced;
   logic             wrong;
   int               fails = 0;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Smallest number of value bytes that a minimal long form of v uses.
   function automatic int minimal_len(input logic [31:0] v);
      int n;
      n = 4;
      if (v < 32'd128) return 0;
      while (n > 1 && v[8*n-1 -: 8] == 8'd0) n--;
      return n;
   endfunction

   // Advances the decoder state by one item and tells whether it ends a field.
   function automatic void decode_length_byte(input vld_pkg::req_type it, output logic done,
                                              output vld_pkg::rsp_type res);
      done = 1'b0;
      res  = '0;
      if (it.source_end) begin
         in_field = 1'b0;
         len_remaining = '0;
         value_acc = '0;
         done = 1'b1;
         res.status = vld_pkg::ST_SHORT;
      end else if (!in_field) begin
         done = 1'b1;
         if (!it.data_byte[7]) begin
            res.decoded_value = {24'd0, it.data_byte};
            res.status = vld_pkg::ST_OK;
         end else if (it.data_byte[6:0] == 7'd0 ||
                      it.data_byte[6:0] > vld_pkg::MaxCount) begin
            res.status = vld_pkg::ST_BAD;
         end else begin
            done = 1'b0;
            in_field = 1'b1;
            announced_len = 4'(it.data_byte[6:0]);
            len_remaining = 4'(it.data_byte[6:0]);
            value_acc = '0;
         end
      end else begin
         value_acc = {value_acc[23:0], it.data_byte};
         len_remaining = len_remaining - 4'd1;
         if (len_remaining == 4'd0) begin
            done = 1'b1;
            in_field = 1'b0;
            if (minimal_len(value_acc) == int'(announced_len)) begin
               res.decoded_value = value_acc;
               res.status = vld_pkg::ST_OK;
            end else begin
               res.status = vld_pkg::ST_BAD;
            end
            value_acc = '0;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         in_field = 1'b0;
         announced_len = '0;
         len_remaining = '0;
         value_acc = '0;
         pending_lengths.delete();
      end else begin
         // Results leave before the item of this edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (pending_lengths.size() == 0) begin
               $display("%0t: unexpected result, got value %0d status %0d", $time,
                        rsp_data.decoded_value, rsp_data.status);
               fails++;
            end else begin
               oldest = pending_lengths.pop_front();
               wrong = 1'b0;
               if (rsp_data.decoded_value !== oldest.decoded_value) begin
                  $display("%0t: decoded_value mismatch, expected %0d, got %0d", $time,
                           oldest.decoded_value, rsp_data.decoded_value);
                  wrong = 1'b1;
               end
               if (rsp_data.status !== oldest.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d", $time,
                           oldest.status, rsp_data.status);
                  wrong = 1'b1;
               end
               if (wrong) fails++;
            end
         end
         if (req_valid && !req_stall) begin
            decode_length_byte(req_data, produced, predicted);
            if (produced) pending_lengths.push_back(predicted);
         end
      end
      error_count   <= fails;
      pending_count <= pending_lengths.size();
   end

endmodule

// ===== bench/tb_vlength_decoder.sv =====
// Top of the length decoder bench: clock, reset, stimulus and the verdict.
// Depends on vld_pkg, vlength_decoder and vld_checker.
`timescale 1ns / 1ps

module tb_vlength_decoder;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   vld_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   vld_pkg::rsp_type rsp_data;

   int error_count;
   int pending_count;

   // Idle and stall chances in percent, set per phase by the stimulus.
   int idle_pct = 0;
   int stall_pct = 0;
   // Raised by the stimulus to make the receiver hold off for a long stretch.
   logic hold_off = 1'b0;
   int   hold_n;
   int   items_sent = 0;

   vlength_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vld_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver. It stalls at random with the current chance; when asked, it
   // holds off without a break so that the decoder fills up and
   // pushes back on its input side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            for (hold_n = 0; hold_n < 60; hold_n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one item, after a random gap, and returns at the edge that takes it.
   // The payload stays put while the decoder stalls.
   task automatic send_item(input vld_pkg::req_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      vld_pkg::req_type it;
      it.data_byte  = b;
      it.source_end = 1'b0;
      send_item(it);
   endtask

   // The byte that travels with an end marker is random, since it is ignored.
   task automatic send_end();
      vld_pkg::req_type it;
      it.data_byte  = 8'($urandom);
      it.source_end = 1'b1;
      send_item(it);
   endtask

   // Sends v as a short form (n is zero) or as a long form of n value bytes.
   task automatic send_encoded(input logic [31:0] v, input int n);
      if (n == 0) begin
         send_byte(v[7:0]);
      end else begin
         send_byte(8'h80 | 8'(n));
         for (int i = n - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
      end
   endtask

   // A value whose minimal long form takes exactly n bytes.
   function automatic logic [31:0] value_of_len(input int n);
      case (n)
         0:       return 32'($urandom_range(127));
         1:       return 32'($urandom_range(255, 128));
         2:       return 32'($urandom_range(65535, 256));
         3:       return 32'($urandom_range(16777215, 65536));
         default: return {8'($urandom_range(255, 1)), 24'($urandom)};
      endcase
   endfunction

   // One random field. Most are well-formed, some are padded with leading
   // zero bytes, some carry a random header, some are cut short by the end
   // marker, and a few are bare end markers or stray bytes.
   task automatic send_field();
      int kind;
      int n;
      int m;
      int k;
      logic [31:0] v;
      kind = $urandom_range(99);
      if (kind < 60) begin
         n = $urandom_range(4);
         v = value_of_len(n);
         send_encoded(v, n);
      end else if (kind < 75) begin
         n = $urandom_range(4, 1);
         m = $urandom_range(n - 1);
         v = value_of_len(m);
         send_encoded(v, n);
      end else if (kind < 83) begin
         send_byte(8'h80 | 8'($urandom_range(127)));
      end else if (kind < 91) begin
         n = $urandom_range(4, 1);
         k = $urandom_range(n - 1);
         send_byte(8'h80 | 8'(n));
         repeat (k) send_byte(8'($urandom));
         send_end();
      end else if (kind < 96) begin
         send_end();
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   // Stops offering and waits until every predicted result has come back.
   // The first edge lets the checker take in the last accepted item.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(input int sender_idle, input int receiver_stall,
                               input int count);
      int target;
      target    = items_sent + count;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      while (items_sent < target) send_field();
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling on either side.
      send_end();                     // end of source while idle
      send_byte(8'h00);               // smallest short form
      send_byte(8'h7F);               // largest short form
      send_byte(8'h80);               // long form announcing zero bytes
      send_byte(8'h85);               // count one above the limit
      send_byte(8'hFF);               // largest count
      send_encoded(32'd128, 1);       // smallest one-byte long form
      send_encoded(32'd127, 1);       // short-form value padded to long form
      send_encoded(32'd256, 2);       // smallest two-byte long form
      send_encoded(32'hFFFF_FFFF, 4); // largest value
      send_encoded(32'h00FF_FFFF, 4); // leading zero byte, not minimal
      send_byte(8'h83);               // end of source in the middle of a field
      send_byte(8'h12);
      send_end();
      drain();

      // Random part in several idling phases, with one long receiver hold-off
      // that fills the decoder while the sender keeps offering short forms.
      random_phase(0, 0, 150);
      idle_pct  = 0;
      stall_pct = 0;
      hold_off  = 1'b1;
      repeat (40) send_byte(8'($urandom_range(127)));
      drain();
      random_phase(59, 0, 150);
      random_phase(0, 59, 150);
      random_phase(10, 10, 150);

      if (error_count == 0 && pending_count == 0) begin
         $display("tb_vlength_decoder passed");
      end else begin
         $display("tb_vlength_decoder failed");
      end
      $finish;
   end

   // Watchdog, far above the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb_vlength_decoder failed");
      $finish;
   end

endmodule
